// ----- hdl/ltc_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ltc_pkg
// Shared widths, the frame-sum word type and the pixel conversion functions
// of the luminance template correlator.
// ---------------------------------------------------------------------------
package ltc_pkg;

   localparam int PROD_W     = 40;
   localparam int MASK_W     = 28;
   localparam int SIM_W      = 48;
   localparam int PIX_W      = 8;
   localparam int PROD_PIX_W = 17;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int DIV_STEPS  = SIM_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int REM_W      = MASK_W + 1;

   typedef struct packed {
      logic signed [PROD_W-1:0] weighted_sum;
      logic signed [MASK_W-1:0] mask_total;
   } frame_sums_type;

   // inverted luminance, q8 weights, rounded up
   function automatic logic [PIX_W-1:0] inv_lum(input logic [PIX_W-1:0] b0,
                                                input logic [PIX_W-1:0] b1,
                                                input logic [PIX_W-1:0] b2);
      logic [15:0] s;
      logic [15:0] r;
      s = 16'd77 * 16'(b0) + 16'd150 * 16'(b1) + 16'd29 * 16'(b2);
      r = (s + 16'd255) >> 8;
      return PIX_W'(16'd255 - r);
   endfunction

   // sigmoid rom
   function automatic logic [PIX_W-1:0] sigmoid(input logic [PIX_W-1:0] d);
      logic [PIX_W-1:0] c;
      case (d)
         8'd117:  c = 8'd1;
         8'd118:  c = 8'd2;
         8'd119:  c = 8'd4;
         8'd120:  c = 8'd6;
         8'd121:  c = 8'd11;
         8'd122:  c = 8'd18;
         8'd123:  c = 8'd29;
         8'd124:  c = 8'd45;
         8'd125:  c = 8'd67;
         8'd126:  c = 8'd95;
         8'd127:  c = 8'd127;
         8'd128:  c = 8'd159;
         8'd129:  c = 8'd187;
         8'd130:  c = 8'd209;
         8'd131:  c = 8'd225;
         8'd132:  c = 8'd236;
         8'd133:  c = 8'd243;
         8'd134:  c = 8'd248;
         8'd135:  c = 8'd250;
         8'd136:  c = 8'd252;
         8'd137:  c = 8'd253;
         default: begin
            if (d < 8'd117) c = 8'd0;
            else if (d < 8'd160) c = 8'd254;
            else c = 8'd255;
         end
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/luminance_template_correlator.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// luminance_template_correlator
// Correlates a mask image against a camera image by inverted luminance.
//
// The req channel takes one mask pixel and one camera pixel per word, one
// word per cycle unless req_stall is high; req_last_pixel closes the frame.
// Non-final pixels give no result. The final pixel gives one rsp word:
// weighted sum, mask total, their q8 quotient (saturated) and a zero-divisor
// flag. The quotient comes from a 48-step bit-serial divider that takes one
// frame at a time. Pixel throughput is one per cycle while req_stall is low.
// A two-word queue holds frame sums; frames shorter than the divider time
// fill it and then req_stall rises on a final pixel until a slot frees.
// rsp_stall holds the result word; the divider then waits, and the front end
// keeps accepting pixels until the queue is full.
// Reset clears the sums, the queue and the output valid.
// ---------------------------------------------------------------------------
module luminance_template_correlator import ltc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [PIX_W-1:0]         req_mask_byte_0,
   input  wire logic [PIX_W-1:0]         req_mask_byte_1,
   input  wire logic [PIX_W-1:0]         req_mask_byte_2,
   input  wire logic [PIX_W-1:0]         req_cam_byte_0,
   input  wire logic [PIX_W-1:0]         req_cam_byte_1,
   input  wire logic [PIX_W-1:0]         req_cam_byte_2,
   input  wire logic                     req_last_pixel,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic signed [PROD_W-1:0] rsp_weighted_sum,
   output      logic signed [MASK_W-1:0] rsp_mask_total,
   output      logic signed [SIM_W-1:0]  rsp_similarity_q8,
   output      logic                     rsp_zero_divisor
);

   logic           q_push, q_pop, q_full, q_empty;
   frame_sums_type push_word, pop_word;

   ltc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mask_byte_0 (req_mask_byte_0),
      .req_mask_byte_1 (req_mask_byte_1),
      .req_mask_byte_2 (req_mask_byte_2),
      .req_cam_byte_0  (req_cam_byte_0),
      .req_cam_byte_1  (req_cam_byte_1),
      .req_cam_byte_2  (req_cam_byte_2),
      .req_last_pixel  (req_last_pixel),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_word          (push_word)
   );

   ltc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .pop       (q_pop),
      .pop_word  (pop_word),
      .full      (q_full),
      .empty     (q_empty)
   );

   ltc_divider u_divider (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_word            (pop_word),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_weighted_sum  (rsp_weighted_sum),
      .rsp_mask_total    (rsp_mask_total),
      .rsp_similarity_q8 (rsp_similarity_q8),
      .rsp_zero_divisor  (rsp_zero_divisor)
   );

endmodule
`default_nettype wire

// ----- hdl/ltc_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ltc_front
// Pixel front end: luminance, sigmoid, product and frame accumulation,
// one pixel per cycle unless stalled; queues the frame sums on the last pixel.
// ---------------------------------------------------------------------------
module ltc_front import ltc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [PIX_W-1:0]     req_mask_byte_0,
   input  wire logic [PIX_W-1:0]     req_mask_byte_1,
   input  wire logic [PIX_W-1:0]     req_mask_byte_2,
   input  wire logic [PIX_W-1:0]     req_cam_byte_0,
   input  wire logic [PIX_W-1:0]     req_cam_byte_1,
   input  wire logic [PIX_W-1:0]     req_cam_byte_2,
   input  wire logic                 req_last_pixel,
   input  wire logic                 q_full,
   output      logic                 q_push,
   output      frame_sums_type       q_word
);

   logic                         adv;
   logic                         s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]             s1_m_ff, s1_m_in;
   logic [PIX_W-1:0]             s1_d_ff, s1_d_in;
   logic                         s1_last_ff, s1_last_in;
   logic                         s2_valid_ff, s2_valid_in;
   logic signed [PIX_W-1:0]      s2_sm_ff, s2_sm_in;
   logic signed [PROD_PIX_W-1:0] s2_prod_ff, s2_prod_in;
   logic                         s2_last_ff, s2_last_in;
   logic [PROD_W-1:0]            pacc_ff, pacc_in;
   logic [MASK_W-1:0]            macc_ff, macc_in;
   logic [PROD_W-1:0]            psum;
   logic [MASK_W-1:0]            msum;
   logic [PIX_W-1:0]             cam_c;
   logic signed [PIX_W:0]        ctr;
   logic signed [PROD_PIX_W-1:0] ctr_ext;
   logic signed [PROD_PIX_W-1:0] sc_ext;

   assign adv       = !(s2_valid_ff && s2_last_ff && q_full);
   assign req_stall = !adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_m_in     = s1_m_ff;
      s1_d_in     = s1_d_ff;
      s1_last_in  = s1_last_ff;
      if (adv) begin
         s1_valid_in = req_valid;
         s1_m_in     = inv_lum(req_mask_byte_0, req_mask_byte_1, req_mask_byte_2);
         s1_d_in     = inv_lum(req_cam_byte_0, req_cam_byte_1, req_cam_byte_2);
         s1_last_in  = req_last_pixel;
      end
   end

   assign cam_c   = sigmoid(s1_d_ff);
   assign ctr     = $signed({s1_m_ff[PIX_W-1], s1_m_ff}) - 9'sd128;
   assign ctr_ext = $signed({{(PROD_PIX_W-PIX_W-1){ctr[PIX_W]}}, ctr});
   assign sc_ext  = $signed({{(PROD_PIX_W-PIX_W){cam_c[PIX_W-1]}}, cam_c});

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_sm_in    = s2_sm_ff;
      s2_prod_in  = s2_prod_ff;
      s2_last_in  = s2_last_ff;
      if (adv) begin
         s2_valid_in = s1_valid_ff;
         s2_sm_in    = $signed(s1_m_ff);
         s2_prod_in  = ctr_ext * sc_ext;
         s2_last_in  = s1_last_ff;
      end
   end

   assign psum = pacc_ff + {{(PROD_W-PROD_PIX_W){s2_prod_ff[PROD_PIX_W-1]}}, s2_prod_ff};
   assign msum = macc_ff + {{(MASK_W-PIX_W){s2_sm_ff[PIX_W-1]}}, s2_sm_ff};

   always_comb begin
      pacc_in = pacc_ff;
      macc_in = macc_ff;
      q_push  = 1'b0;
      if (s2_valid_ff && adv) begin
         if (s2_last_ff) begin
            q_push  = 1'b1;
            pacc_in = '0;
            macc_in = '0;
         end else begin
            pacc_in = psum;
            macc_in = msum;
         end
      end
   end

   assign q_word.weighted_sum = $signed(psum);
   assign q_word.mask_total   = $signed(msum);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         pacc_ff     <= '0;
         macc_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         pacc_ff     <= pacc_in;
         macc_ff     <= macc_in;
      end
      s1_m_ff    <= s1_m_in;
      s1_d_ff    <= s1_d_in;
      s1_last_ff <= s1_last_in;
      s2_sm_ff   <= s2_sm_in;
      s2_prod_ff <= s2_prod_in;
      s2_last_ff <= s2_last_in;
   end

endmodule
`default_nettype wire

// ----- hdl/ltc_fifo.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ltc_fifo
// Short queue of frame-sum words between the pixel front end and the divider.
// ---------------------------------------------------------------------------
module ltc_fifo import ltc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire frame_sums_type push_word,
   input  wire logic           pop,
   output      frame_sums_type pop_word,
   output      logic           full,
   output      logic           empty
);

   frame_sums_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign full     = (cnt_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/ltc_divider.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ltc_divider
// Back end: takes a frame-sum word, forms the q8 quotient with a restoring
// divider one bit per cycle, saturates it and holds the result word.
// ---------------------------------------------------------------------------
module ltc_divider import ltc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_empty,
   input  wire frame_sums_type     q_word,
   output      logic               q_pop,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic signed [PROD_W-1:0] rsp_weighted_sum,
   output      logic signed [MASK_W-1:0] rsp_mask_total,
   output      logic signed [SIM_W-1:0]  rsp_similarity_q8,
   output      logic               rsp_zero_divisor
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_type;

   state_type                state_ff, state_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SIM_W-1:0]         quo_ff, quo_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [MASK_W-1:0]        dvs_ff, dvs_in;
   logic                     neg_ff, neg_in;
   logic                     zero_ff, zero_in;
   frame_sums_type           sums_ff, sums_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [PROD_W-1:0] out_ws_ff, out_ws_in;
   logic signed [MASK_W-1:0] out_mt_ff, out_mt_in;
   logic signed [SIM_W-1:0]  out_q_ff, out_q_in;
   logic                     out_zero_ff, out_zero_in;
   logic [SIM_W-1:0]         dividend;
   logic [REM_W-1:0]         rem_sh;
   logic [SIM_W-1:0]         q_final;
   logic                     out_free;

   assign dividend = {q_word.weighted_sum, 8'd0};
   assign rem_sh   = {rem_ff[REM_W-2:0], quo_ff[SIM_W-1]};
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      if (zero_ff) begin
         q_final = '0;
      end else if (neg_ff) begin
         q_final = '0 - quo_ff;
      end else if (quo_ff[SIM_W-1]) begin
         q_final = {1'b0, {(SIM_W-1){1'b1}}};
      end else begin
         q_final = quo_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      sums_in      = sums_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_ws_in    = out_ws_ff;
      out_mt_in    = out_mt_ff;
      out_q_in     = out_q_ff;
      out_zero_in  = out_zero_ff;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               sums_in = q_word;
               zero_in = (q_word.mask_total == '0);
               neg_in  = q_word.weighted_sum[PROD_W-1] ^ q_word.mask_total[MASK_W-1];
               quo_in  = dividend[SIM_W-1] ? ('0 - dividend) : dividend;
               dvs_in  = q_word.mask_total[MASK_W-1] ?
                         ('0 - q_word.mask_total) : q_word.mask_total;
               rem_in  = '0;
               cnt_in  = '0;
               state_in = (q_word.mask_total == '0) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_in = rem_sh - {1'b0, dvs_ff};
               quo_in = {quo_ff[SIM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[SIM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_ws_in    = sums_ff.weighted_sum;
               out_mt_in    = sums_ff.mask_total;
               out_q_in     = $signed(q_final);
               out_zero_in  = zero_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff      <= cnt_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      sums_ff     <= sums_in;
      out_ws_ff   <= out_ws_in;
      out_mt_ff   <= out_mt_in;
      out_q_ff    <= out_q_in;
      out_zero_ff <= out_zero_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_weighted_sum  = out_ws_ff;
   assign rsp_mask_total    = out_mt_ff;
   assign rsp_similarity_q8 = out_q_ff;
   assign rsp_zero_divisor  = out_zero_ff;

endmodule
`default_nettype wire

// ----- verif/luminance_template_correlator_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// luminance_template_correlator_tb
// Self-checking bench for the luminance template correlator. A directed
// table covers byte extremes, the sigmoid band edges, the signed-byte edge,
// a zero mask total and back-to-back frames. Random frames follow, mostly
// short with a few long ones. Both channels idle at random. At one point the
// result side holds off long enough that the frame queue fills and the pixel
// side stalls. Every result word is checked field by field, oldest expectation
// first, against a typed value (some directed frames) or an in-bench predictor.
// ---------------------------------------------------------------------------
module luminance_template_correlator_tb;
   import ltc_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_ITEMS   = 650;
   localparam int PRESSURE_WORDS = 30;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 120;
   localparam longint SIM_MAX    = (longint'(1) << (SIM_W - 1)) - longint'(1);
   localparam longint SIM_MIN    = -(longint'(1) << (SIM_W - 1));
   // sigmoid entries for dark levels 117..137, first entry in the top byte
   localparam logic [8*21-1:0] CURVE_BAND = {
      8'd1,   8'd2,   8'd4,   8'd6,   8'd11,  8'd18,  8'd29,  8'd45,  8'd67,
      8'd95,  8'd127, 8'd159, 8'd187, 8'd209, 8'd225, 8'd236, 8'd243, 8'd248,
      8'd250, 8'd252, 8'd253
   };

   typedef enum int {PIX_NOISE, PIX_GRAY_BAND, PIX_EXTREME} pixel_mode_type;

   typedef struct {
      logic signed [PROD_W-1:0] weighted_sum;
      logic signed [MASK_W-1:0] mask_total;
      logic signed [SIM_W-1:0]  similarity_q8;
      logic                     zero_divisor;
   } frame_result_type;

   typedef struct {
      logic [2:0][PIX_W-1:0] mask;
      logic [2:0][PIX_W-1:0] cam;
      logic                  last;
      bit                    typed;
      frame_result_type      want;
   } pixel_word_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [PIX_W-1:0]         req_mask_byte_0;
   logic [PIX_W-1:0]         req_mask_byte_1;
   logic [PIX_W-1:0]         req_mask_byte_2;
   logic [PIX_W-1:0]         req_cam_byte_0;
   logic [PIX_W-1:0]         req_cam_byte_1;
   logic [PIX_W-1:0]         req_cam_byte_2;
   logic                     req_last_pixel;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [PROD_W-1:0] rsp_weighted_sum;
   logic signed [MASK_W-1:0] rsp_mask_total;
   logic signed [SIM_W-1:0]  rsp_similarity_q8;
   logic                     rsp_zero_divisor;

   logic [PROD_W-1:0] prod_sum = '0;
   logic [MASK_W-1:0] mask_sum = '0;
   frame_result_type  expected_frames[$];
   pixel_word_type    directed_rows[$];
   int                mismatch_count = 0;
   int                results_seen = 0;
   int                idle_cycles = 0;
   bit                hold_rsp = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   luminance_template_correlator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mask_byte_0   (req_mask_byte_0),
      .req_mask_byte_1   (req_mask_byte_1),
      .req_mask_byte_2   (req_mask_byte_2),
      .req_cam_byte_0    (req_cam_byte_0),
      .req_cam_byte_1    (req_cam_byte_1),
      .req_cam_byte_2    (req_cam_byte_2),
      .req_last_pixel    (req_last_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_weighted_sum  (rsp_weighted_sum),
      .rsp_mask_total    (rsp_mask_total),
      .rsp_similarity_q8 (rsp_similarity_q8),
      .rsp_zero_divisor  (rsp_zero_divisor)
   );

   function automatic logic [PIX_W-1:0] dark_level(input logic [2:0][PIX_W-1:0] px);
      int unsigned weighted;
      weighted = 77 * px[0] + 150 * px[1] + 29 * px[2];
      return PIX_W'(255 - ((weighted + 255) >> 8));
   endfunction

   function automatic logic [PIX_W-1:0] contrast_curve(input logic [PIX_W-1:0] d);
      if (d < 8'd117) return 8'd0;
      if (d <= 8'd137) return CURVE_BAND[8*(137 - int'(d)) +: 8];
      if (d < 8'd160) return 8'd254;
      return 8'd255;
   endfunction

   task automatic predict_pixel(input pixel_word_type w, output bit done,
                                output frame_result_type r);
      logic signed [PIX_W-1:0] sm;
      logic signed [PIX_W-1:0] sc;
      longint prod;
      longint quo;
      sm = dark_level(w.mask);
      sc = contrast_curve(dark_level(w.cam));
      prod = (longint'(sm) - longint'(128)) * longint'(sc);
      prod_sum = prod_sum + PROD_W'(prod);
      mask_sum = mask_sum + MASK_W'(longint'(sm));
      done = w.last;
      r = '{default: '0};
      if (w.last) begin
         r.weighted_sum = prod_sum;
         r.mask_total = mask_sum;
         r.zero_divisor = (mask_sum == '0);
         if (!r.zero_divisor) begin
            quo = (longint'(r.weighted_sum) * longint'(256)) / longint'(r.mask_total);
            if (quo > SIM_MAX) quo = SIM_MAX;
            if (quo < SIM_MIN) quo = SIM_MIN;
            r.similarity_q8 = quo[SIM_W-1:0];
         end
         prod_sum = '0;
         mask_sum = '0;
      end
   endtask

   function automatic logic [2:0][PIX_W-1:0] random_pixel(input pixel_mode_type mode);
      logic [2:0][PIX_W-1:0] px;
      logic [PIX_W-1:0] g;
      case (mode)
         PIX_GRAY_BAND: begin
            g = PIX_W'($urandom_range(90, 145));
            px = {g, g, g};
         end
         PIX_EXTREME: begin
            for (int i = 0; i < 3; i++) px[i] = $urandom_range(0, 1) ? 8'hff : 8'h00;
         end
         default: px = 24'($urandom);
      endcase
      return px;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   task automatic add_row(input int m0, m1, m2, c0, c1, c2, last);
      pixel_word_type w;
      w.mask = {8'(m2), 8'(m1), 8'(m0)};
      w.cam = {8'(c2), 8'(c1), 8'(c0)};
      w.last = 1'(last);
      w.typed = 1'b0;
      w.want = '{default: '0};
      directed_rows.push_back(w);
   endtask

   task automatic type_result(input longint ws, mt, q, input bit zd);
      int n;
      n = directed_rows.size() - 1;
      directed_rows[n].typed = 1'b1;
      directed_rows[n].want.weighted_sum = PROD_W'(ws);
      directed_rows[n].want.mask_total = MASK_W'(mt);
      directed_rows[n].want.similarity_q8 = SIM_W'(q);
      directed_rows[n].want.zero_divisor = zd;
   endtask

   task automatic send_word(input pixel_word_type w, input int gap);
      bit done;
      frame_result_type r;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mask_byte_0 <= w.mask[0];
      req_mask_byte_1 <= w.mask[1];
      req_mask_byte_2 <= w.mask[2];
      req_cam_byte_0 <= w.cam[0];
      req_cam_byte_1 <= w.cam[1];
      req_cam_byte_2 <= w.cam[2];
      req_last_pixel <= w.last;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_pixel(w, done, r);
      if (done) expected_frames.push_back(w.typed ? w.want : r);
   endtask

   initial begin : pixel_source
      pixel_word_type w;
      int sent;
      int frame_len;
      bit quiet;
      bit pressure_done;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mask_byte_0 = '0;
      req_mask_byte_1 = '0;
      req_mask_byte_2 = '0;
      req_cam_byte_0 = '0;
      req_cam_byte_1 = '0;
      req_cam_byte_2 = '0;
      req_last_pixel = 1'b0;
      sent = 0;
      pressure_done = 1'b0;

      add_row(0, 0, 0, 0, 0, 0, 1);
      type_result(129, -1, -33024, 1'b0);
      add_row(255, 255, 255, 255, 255, 255, 1);
      type_result(0, 0, 0, 1'b1);
      add_row(128, 128, 128, 128, 128, 128, 1);
      type_result(-127, 127, -256, 1'b0);
      add_row(0, 0, 0, 255, 255, 255, 1);
      type_result(0, -1, 0, 1'b0);
      // sigmoid band edges, signed byte edge, single-byte extremes
      add_row(127, 127, 127, 139, 139, 139, 0);
      add_row(126, 126, 126, 138, 138, 138, 0);
      add_row(255, 0, 0, 118, 118, 118, 0);
      add_row(0, 255, 0, 117, 117, 117, 0);
      add_row(0, 0, 255, 96, 96, 96, 0);
      add_row(129, 129, 129, 95, 95, 95, 0);
      add_row(255, 0, 255, 255, 0, 0, 0);
      add_row(0, 255, 255, 0, 255, 0, 0);
      add_row(200, 100, 50, 0, 0, 255, 1);
      // mask total cancels to zero over two pixels
      add_row(254, 254, 254, 10, 20, 30, 0);
      add_row(0, 0, 0, 128, 128, 128, 1);
      add_row(17, 34, 51, 127, 127, 127, 0);
      add_row(255, 255, 255, 0, 0, 0, 1);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_word(directed_rows[i], $urandom_range(0, 13));

      while (sent < RANDOM_ITEMS) begin
         if (!pressure_done && sent >= RANDOM_ITEMS / 2) begin
            // result side holds off while single-pixel frames pile up
            pressure_done = 1'b1;
            hold_rsp = 1'b1;
            repeat (PRESSURE_WORDS) begin
               w.mask = random_pixel(PIX_NOISE);
               w.cam = random_pixel(PIX_GRAY_BAND);
               w.last = 1'b1;
               w.typed = 1'b0;
               send_word(w, 0);
               sent++;
            end
         end else begin
            frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80)
                                                     : $urandom_range(1, 12);
            quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < frame_len; i++) begin
               w.mask = random_pixel(pixel_mode_type'($urandom_range(0, 2)));
               w.cam = random_pixel(pixel_mode_type'($urandom_range(0, 2)));
               w.last = (i == frame_len - 1);
               w.typed = 1'b0;
               send_word(w, quiet ? 0 : $urandom_range(0, 13));
               sent++;
            end
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (expected_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_frames.size() != 0)
         report_mismatch($sformatf("%0d result words never arrived", expected_frames.size()));
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : result_sink
      int wait_cycles;
      bit steady;
      rsp_stall = 1'b0;
      steady = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 5) == 0) steady = !steady;
         wait_cycles = steady ? 0 : $urandom_range(0, 13);
         if (hold_rsp) begin
            wait_cycles = HOLD_CYCLES;
            hold_rsp = 1'b0;
         end
         repeat (wait_cycles) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin : result_check
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected result word, weighted_sum %0d",
                                      rsp_weighted_sum));
         end else begin
            want = expected_frames.pop_front();
            if (rsp_weighted_sum !== want.weighted_sum)
               report_mismatch($sformatf("word %0d weighted_sum: got %0d, expected %0d",
                               results_seen, rsp_weighted_sum, want.weighted_sum));
            if (rsp_mask_total !== want.mask_total)
               report_mismatch($sformatf("word %0d mask_total: got %0d, expected %0d",
                               results_seen, rsp_mask_total, want.mask_total));
            if (rsp_similarity_q8 !== want.similarity_q8)
               report_mismatch($sformatf("word %0d similarity_q8: got %0d, expected %0d",
                               results_seen, rsp_similarity_q8, want.similarity_q8));
            if (rsp_zero_divisor !== want.zero_divisor)
               report_mismatch($sformatf("word %0d zero_divisor: got %0b, expected %0b",
                               results_seen, rsp_zero_divisor, want.zero_divisor));
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no word moved for %0d cycles", idle_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ----- files.f -----
hdl/ltc_pkg.sv
hdl/ltc_front.sv
hdl/ltc_fifo.sv
hdl/ltc_divider.sv
hdl/luminance_template_correlator.sv
verif/luminance_template_correlator_tb.sv
